FILE: hw/rtl/csa_pkg.sv
package csa_pkg;

    localparam int OBJ_W     = 24;
    localparam int OUT_W     = 26;
    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 1;
    localparam int PROD_W    = 2 * CFG_W;
    localparam int OBJ_MAX   = (1 << OBJ_W) - 1;
    localparam int PROD_MAX  = ((1 << CFG_W) - 1) * ((1 << CFG_W) - 1);

    localparam logic [CFG_IDX_W-1:0] REG_RANK = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CHAN = 1'b1;

    // Datapath operations selected by the microcode.
    typedef enum logic [2:0] {
        OP_NOP       = 3'd0,
        OP_LOAD      = 3'd1,
        OP_DIV       = 3'd2,
        OP_LD_MOD    = 3'd3,
        OP_GCD_INIT  = 3'd4,
        OP_GCD_STEP  = 3'd5,
        OP_BUMP      = 3'd6,
        OP_EMIT      = 3'd7
    } t_op;

    typedef struct packed {
        t_op  op;
        logic idle;
    } t_ctrl;

    typedef struct packed {
        logic in_valid;
        logic div_more;
        logic pad_off;
        logic gcd_more;
        logic coprime;
        logic out_blocked;
    } t_status;

endpackage

FILE: hw/rtl/csa_useq.sv
module csa_useq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  csa_pkg::t_status  i_status,
    output csa_pkg::t_ctrl    o_ctrl
);

    localparam int PC_W = 4;

    typedef enum logic [2:0] {
        C_NEVER       = 3'd0,
        C_ALWAYS      = 3'd1,
        C_NO_INPUT    = 3'd2,
        C_DIV_MORE    = 3'd3,
        C_PAD_OFF     = 3'd4,
        C_GCD_MORE    = 3'd5,
        C_COPRIME     = 3'd6,
        C_OUT_BLOCKED = 3'd7
    } t_cond;

    typedef struct packed {
        csa_pkg::t_op       op;
        t_cond              cond;
        logic               fin;
        logic [PC_W-1:0]    target;
    } t_uword;

    localparam logic [PC_W-1:0] PC_WAIT = 4'd0;
    localparam logic [PC_W-1:0] PC_MOD  = 4'd1;
    localparam logic [PC_W-1:0] PC_DIV  = 4'd2;
    localparam logic [PC_W-1:0] PC_GINI = 4'd3;
    localparam logic [PC_W-1:0] PC_GCD  = 4'd4;
    localparam logic [PC_W-1:0] PC_TEST = 4'd5;
    localparam logic [PC_W-1:0] PC_BUMP = 4'd6;
    localparam logic [PC_W-1:0] PC_EMIT = 4'd7;

    // The program: a jump is taken when the condition holds, otherwise the
    // step counter moves on, or returns to the wait step after the last word.
    function automatic t_uword rom(input logic [PC_W-1:0] pc);
        t_uword w;
        unique case (pc)
            PC_WAIT: w = '{csa_pkg::OP_LOAD,     C_NO_INPUT,    1'b0, PC_WAIT};
            PC_MOD:  w = '{csa_pkg::OP_LD_MOD,   C_PAD_OFF,     1'b0, PC_EMIT};
            PC_DIV:  w = '{csa_pkg::OP_DIV,      C_DIV_MORE,    1'b0, PC_DIV};
            PC_GINI: w = '{csa_pkg::OP_GCD_INIT, C_NEVER,       1'b0, PC_WAIT};
            PC_GCD:  w = '{csa_pkg::OP_GCD_STEP, C_GCD_MORE,    1'b0, PC_GCD};
            PC_TEST: w = '{csa_pkg::OP_NOP,      C_COPRIME,     1'b0, PC_EMIT};
            PC_BUMP: w = '{csa_pkg::OP_BUMP,     C_ALWAYS,      1'b0, PC_GCD};
            PC_EMIT: w = '{csa_pkg::OP_EMIT,     C_OUT_BLOCKED, 1'b1, PC_EMIT};
            default: w = '{csa_pkg::OP_NOP,      C_ALWAYS,      1'b0, PC_WAIT};
        endcase
        return w;
    endfunction

    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    t_uword          w_word;
    logic            w_take;

    assign w_word = rom(r_pc);

    always_comb begin
        unique case (w_word.cond)
            C_NEVER:       w_take = 1'b0;
            C_ALWAYS:      w_take = 1'b1;
            C_NO_INPUT:    w_take = !i_status.in_valid;
            C_DIV_MORE:    w_take = i_status.div_more;
            C_PAD_OFF:     w_take = i_status.pad_off;
            C_GCD_MORE:    w_take = i_status.gcd_more;
            C_COPRIME:     w_take = i_status.coprime;
            C_OUT_BLOCKED: w_take = i_status.out_blocked;
            default:       w_take = 1'b0;
        endcase
        if (w_take) begin
            n_pc = w_word.target;
        end else if (w_word.fin) begin
            n_pc = PC_WAIT;
        end else begin
            n_pc = r_pc + PC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_WAIT;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ctrl.op   = w_word.op;
    assign o_ctrl.idle = (r_pc == PC_WAIT);

endmodule

FILE: hw/rtl/coprime_stride_size_align_unit.sv
// Coprime stride size alignment unit.
//
// An object size word enters on the input channel (i_in_valid / o_in_stall)
// and one stride word leaves on the output channel (o_out_valid /
// i_out_stall). The stride is the size rounded up to whole lines, with the
// line count then raised until it shares no factor with rank_count times
// channel_count; with either count at zero the rounded size is returned.
// The two counts are written through the plain write port (i_cfg_we, i_cfg_index,
// i_cfg_wdata); the user must write them only while the unit is idle; it is not enforced.
//
// Work is one item at a time under a small microcoded sequencer. The accept latches the size
// plus LINE_BYTES - 1; the next cycle multiplies that by the reciprocal of the line size to
// get the line count. With padding off the emit step comes next and loads the output register.
// With padding on, 25 shift-and-subtract steps take the count modulo the product and one
// step sets up the gcd. Each candidate count then gets a binary gcd test and a test step,
// and one more step when it fails; the emit step follows the first count that passes.
//
// Reset clears the sequencer, the output valid flag and both counts. While the receiver
// stalls, the finished word waits in the output register and the sequencer may already take
// the next input word; it holds at its final step only when that next result is ready.
module coprime_stride_size_align_unit #(
    parameter int LINE_BYTES = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [csa_pkg::OBJ_W-1:0]     i_object_bytes,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [csa_pkg::OUT_W-1:0]     o_stride_bytes,
    input  logic                          i_cfg_we,
    input  logic [csa_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [csa_pkg::CFG_W-1:0]     i_cfg_wdata
);

    localparam int PROD_W    = csa_pkg::PROD_W;
    localparam int LB_W      = $clog2(LINE_BYTES + 1);
    localparam int DIVD_W    = $clog2(csa_pkg::OBJ_MAX + LINE_BYTES);
    localparam int DIVR_W    = PROD_W;
    localparam int CNT_W     = $clog2(DIVD_W + 1);
    localparam int MAX_LINES = (csa_pkg::OBJ_MAX + LINE_BYTES - 1) / LINE_BYTES
                               + csa_pkg::PROD_MAX;
    localparam int LINES_W   = $clog2(MAX_LINES + 1);
    localparam int MUL_RAW   = LINES_W + LB_W;
    localparam int MUL_W     = (MUL_RAW > csa_pkg::OUT_W) ? MUL_RAW : csa_pkg::OUT_W;

    // Division by the line size is a multiply by ceil(2^RECIP_SH / LINE_BYTES)
    // and a shift; with RECIP_SH = DIVD_W + log2 of the line size it is exact
    // for every dividend below 2^DIVD_W.
    localparam int RECIP_SH  = DIVD_W + $clog2(LINE_BYTES);
    localparam int RECIP_W   = DIVD_W + 1;
    localparam int SCALE_W   = DIVD_W + RECIP_W;
    localparam longint RECIP_FULL = ((longint'(1) << RECIP_SH) + longint'(LINE_BYTES)
                                     - longint'(1)) / longint'(LINE_BYTES);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

    // Configuration registers and their product, refreshed every cycle.
    logic [csa_pkg::CFG_W-1:0] r_rank;
    logic [csa_pkg::CFG_W-1:0] r_chan;
    logic [PROD_W-1:0]         r_prod;

    // Shift-and-subtract divider for the residue: r_quo holds the dividend
    // and collects the quotient bits as they are produced.
    logic [DIVD_W-1:0]  r_quo;
    logic [DIVR_W-1:0]  r_rem;
    logic [DIVR_W-1:0]  r_dvsr;
    logic [CNT_W-1:0]   r_cnt;

    // Candidate line count, its residue modulo the product and the gcd pair.
    logic [LINES_W-1:0] r_lines;
    logic [PROD_W-1:0]  r_res;
    logic [PROD_W-1:0]  r_ga;
    logic [PROD_W-1:0]  r_gb;

    logic                      r_out_valid;
    logic [csa_pkg::OUT_W-1:0] r_out;

    csa_pkg::t_ctrl   w_ctrl;
    csa_pkg::t_status w_status;

    logic [DIVR_W:0]   w_shift;
    logic              w_ge;
    logic [DIVR_W:0]   w_diff;
    logic              w_gcd_done;
    logic [PROD_W:0]   w_res_inc;
    logic [PROD_W-1:0] w_res_next;
    logic [MUL_W-1:0]  w_mul;
    logic [SCALE_W-1:0] w_scaled;
    logic [LINES_W-1:0] w_lines0;

    csa_useq u_useq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_ctrl   (w_ctrl)
    );

    // Rounded-up line count from the latched size plus LINE_BYTES - 1.
    assign w_scaled = SCALE_W'(r_quo) * SCALE_W'(RECIP);
    assign w_lines0 = w_scaled[RECIP_SH +: LINES_W];

    // One restoring division step.
    assign w_shift = {r_rem, r_quo[DIVD_W-1]};
    assign w_ge    = (w_shift >= {1'b0, r_dvsr});
    assign w_diff  = w_shift - {1'b0, r_dvsr};

    // The binary gcd stops on a zero residue, on equal values, or as soon as
    // both are even, which already rules out a gcd of one.
    assign w_gcd_done = (r_ga == '0) || (r_ga == r_gb) || (!r_ga[0] && !r_gb[0]);

    assign w_res_inc  = {1'b0, r_res} + (PROD_W + 1)'(1);
    assign w_res_next = (w_res_inc == {1'b0, r_prod}) ? '0 : w_res_inc[PROD_W-1:0];

    assign w_mul = MUL_W'(r_lines) * MUL_W'(LINE_BYTES);

    always_comb begin
        w_status.in_valid    = i_in_valid;
        w_status.div_more    = (r_cnt != CNT_W'(1));
        w_status.pad_off     = (r_prod == '0);
        w_status.gcd_more    = !w_gcd_done;
        w_status.coprime     = (r_ga == '0) ? (r_gb == PROD_W'(1))
                                            : ((r_ga == PROD_W'(1)) && (r_gb == PROD_W'(1)));
        w_status.out_blocked = r_out_valid && i_out_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rank <= '0;
            r_chan <= '0;
            r_prod <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    csa_pkg::REG_RANK: r_rank <= i_cfg_wdata;
                    csa_pkg::REG_CHAN: r_chan <= i_cfg_wdata;
                    default: ;
                endcase
            end
            r_prod <= PROD_W'(r_rank) * PROD_W'(r_chan);
        end
    end

    always_ff @(posedge i_clk) begin
        case (w_ctrl.op)
            csa_pkg::OP_LOAD: begin
                r_quo <= DIVD_W'(i_object_bytes) + DIVD_W'(LINE_BYTES - 1);
            end
            csa_pkg::OP_DIV: begin
                r_quo <= {r_quo[DIVD_W-2:0], w_ge};
                r_rem <= w_ge ? w_diff[DIVR_W-1:0] : w_shift[DIVR_W-1:0];
                r_cnt <= r_cnt - CNT_W'(1);
            end
            csa_pkg::OP_LD_MOD: begin
                r_lines <= w_lines0;
                r_quo   <= DIVD_W'(w_lines0);
                r_rem   <= '0;
                r_dvsr  <= DIVR_W'(r_prod);
                r_cnt   <= CNT_W'(DIVD_W);
            end
            csa_pkg::OP_GCD_INIT: begin
                r_res <= r_rem[PROD_W-1:0];
                r_ga  <= r_rem[PROD_W-1:0];
                r_gb  <= r_prod;
            end
            csa_pkg::OP_GCD_STEP: begin
                if (!w_gcd_done) begin
                    if (!r_ga[0]) begin
                        r_ga <= r_ga >> 1;
                    end else if (!r_gb[0]) begin
                        r_gb <= r_gb >> 1;
                    end else if (r_ga > r_gb) begin
                        r_ga <= r_ga - r_gb;
                    end else begin
                        r_gb <= r_gb - r_ga;
                    end
                end
            end
            csa_pkg::OP_BUMP: begin
                r_lines <= r_lines + LINES_W'(1);
                r_res   <= w_res_next;
                r_ga    <= w_res_next;
                r_gb    <= r_prod;
            end
            csa_pkg::OP_EMIT: begin
                if (!w_status.out_blocked) begin
                    r_out <= w_mul[csa_pkg::OUT_W-1:0];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctrl.op == csa_pkg::OP_EMIT && !w_status.out_blocked) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_in_stall     = !w_ctrl.idle || !i_rst_n;
    assign o_out_valid    = r_out_valid;
    assign o_stride_bytes = r_out;

`ifndef NO_ASSERTIONS
    // An accepted word keeps the unit busy for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken again straight after an accept");

    // The residue tracked alongside the line count stays below the product.
    a_res_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctrl.op == csa_pkg::OP_GCD_STEP) |-> (r_res < r_prod))
        else $error("residue out of range during gcd test");

    // The output valid flag is only raised by the emit step.
    a_valid_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_ctrl.op == csa_pkg::OP_EMIT))
        else $error("output valid raised outside the emit step");

    // A pending word is never overwritten by a new result.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctrl.op == csa_pkg::OP_EMIT && r_out_valid && i_out_stall)
        |=> $stable(o_stride_bytes))
        else $error("pending stride overwritten");
`endif

endmodule

FILE: verif/tb_coprime_stride_size_align_unit.sv
// Testbench for the coprime stride size alignment unit.
//
// Object size words are pushed through the input channel and every stride word
// that comes back is compared with a prediction made inside the testbench. The
// prediction rounds the size up to whole lines. When both counts are non-zero,
// it then steps the line count until it shares no factor with their product.
// The counts are changed only while nothing is in flight, so each prediction
// uses the counts that were in force when its size word was taken.

module tb_coprime_stride_size_align_unit;

    localparam int          LINE_BYTES   = 64;
    localparam int unsigned CYCLE_LIMIT  = 3_000_000;
    localparam int unsigned DRAIN_CYCLES = 400;
    localparam int unsigned RX_HOLD      = 600;
    localparam int unsigned PHASES       = 12;
    localparam int unsigned PHASE_WORDS  = 113;

    // Keeps the expected stride words and mirrors the two count registers.
    class stride_ledger;
        logic [csa_pkg::CFG_W-1:0] rank_count;
        logic [csa_pkg::CFG_W-1:0] channel_count;
        logic [csa_pkg::OUT_W-1:0] expected_strides[$];
        int unsigned               fail_count;

        function new();
            rank_count    = '0;
            channel_count = '0;
            fail_count    = 0;
        endfunction

        function void set_count(logic [csa_pkg::CFG_IDX_W-1:0] idx,
                                logic [csa_pkg::CFG_W-1:0] val);
            if (idx == csa_pkg::REG_RANK) begin
                rank_count = val;
            end else begin
                channel_count = val;
            end
        endfunction

        function int unsigned common_factor(int unsigned a, int unsigned b);
            int unsigned t;
            if (a == 0) begin
                return b;
            end
            while (b != 0) begin
                t = a % b;
                a = b;
                b = t;
            end
            return a;
        endfunction

        function logic [csa_pkg::OUT_W-1:0] padded_stride(logic [csa_pkg::OBJ_W-1:0] size);
            int unsigned lines;
            int unsigned interleave;
            lines = (int'(size) + LINE_BYTES - 1) / LINE_BYTES;
            if (rank_count != 0 && channel_count != 0) begin
                interleave = int'(rank_count) * int'(channel_count);
                while (common_factor(lines, interleave) != 1) begin
                    lines++;
                end
            end
            return csa_pkg::OUT_W'(lines * LINE_BYTES);
        endfunction

        function void note_object(logic [csa_pkg::OBJ_W-1:0] size);
            expected_strides.push_back(padded_stride(size));
        endfunction

        function void check_stride(logic [csa_pkg::OUT_W-1:0] got);
            logic [csa_pkg::OUT_W-1:0] want;
            if (expected_strides.size() == 0) begin
                fail_count++;
                if (fail_count <= 10) begin
                    $display("unexpected stride word: got %0d", got);
                end
                return;
            end
            want = expected_strides.pop_front();
            if (got !== want) begin
                fail_count++;
                if (fail_count <= 10) begin
                    $display("stride_bytes: expected %0d, got %0d", want, got);
                end
            end
        endfunction

        function int unsigned pending();
            return expected_strides.size();
        endfunction

        function bit clean();
            return fail_count == 0 && expected_strides.size() == 0;
        endfunction
    endclass

    logic                          i_clk          = 1'b0;
    logic                          i_rst_n        = 1'b0;
    logic                          i_in_valid     = 1'b0;
    logic                          o_in_stall;
    logic [csa_pkg::OBJ_W-1:0]     i_object_bytes = '0;
    logic                          o_out_valid;
    logic                          i_out_stall    = 1'b0;
    logic [csa_pkg::OUT_W-1:0]     o_stride_bytes;
    logic                          i_cfg_we       = 1'b0;
    logic [csa_pkg::CFG_IDX_W-1:0] i_cfg_index    = '0;
    logic [csa_pkg::CFG_W-1:0]     i_cfg_wdata    = '0;

    // Idle rates in percent. The sender's rate is read only by the stimulus
    // process; the receiver's rate and the hold request are updated with
    // nonblocking assignments so that the receiver sees them a clean edge later.
    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    logic        rx_hold_req = 1'b0;
    int unsigned cycle_count = 0;

    stride_ledger ledger = new();

    coprime_stride_size_align_unit #(
        .LINE_BYTES(LINE_BYTES)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_object_bytes (i_object_bytes),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_stride_bytes (o_stride_bytes),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // The watchdog ends a run that has hung.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("coprime_stride_size_align_unit: mismatch");
            $finish;
        end
    end

    // The receiver checks every stride word taken at this edge, using the values
    // from just before the edge, and then chooses its stall for the next cycle.
    // A single long hold is counted here once the stimulus asks for it.
    initial begin : receiver
        int unsigned hold_left;
        bit          hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                ledger.check_stride(o_stride_bytes);
            end
            if (rx_hold_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = RX_HOLD;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
            end
        end
    end

    // Offers one size word, possibly after a few idle cycles, and returns at the
    // edge where it is taken. The valid flag stays high on return, so a word
    // that follows straight on needs no extra assignment in the same step.
    task automatic send_word(input logic [csa_pkg::OBJ_W-1:0] size);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_object_bytes <= size;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        ledger.note_object(size);
    endtask

    // Stops offering and waits until every expected stride word has come back.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (ledger.pending() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Writes both counts on two consecutive edges. The unit must be at rest.
    task automatic set_counts(input logic [csa_pkg::CFG_W-1:0] ranks,
                              input logic [csa_pkg::CFG_W-1:0] channels);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= csa_pkg::REG_RANK;
        i_cfg_wdata <= ranks;
        @(posedge i_clk);
        ledger.set_count(csa_pkg::REG_RANK, ranks);
        i_cfg_index <= csa_pkg::REG_CHAN;
        i_cfg_wdata <= channels;
        @(posedge i_clk);
        ledger.set_count(csa_pkg::REG_CHAN, channels);
        i_cfg_we <= 1'b0;
    endtask

    initial begin : stimulus
        logic [csa_pkg::CFG_W-1:0] rank_pick[8];
        logic [csa_pkg::CFG_W-1:0] chan_pick[8];
        logic [csa_pkg::OBJ_W-1:0] size;
        int unsigned               k;

        // Count settings for the first random phases: the extremes, a product
        // with four distinct primes, and each count zeroed on its own.
        rank_pick = '{5'd1, 5'd31, 5'd0, 5'd15, 5'd16, 5'd31, 5'd30, 5'd0};
        chan_pick = '{5'd1, 5'd31, 5'd31, 5'd14, 5'd16, 5'd0, 5'd28, 5'd0};

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_idle_pct = 24;
        rx_idle_pct <= 82;

        // With both counts at their reset value of zero, padding is off.
        send_word('0);
        send_word(csa_pkg::OBJ_W'(csa_pkg::OBJ_MAX));

        // A product of one: a zero size stays zero and every count is coprime.
        settle();
        set_counts(5'd1, 5'd1);
        send_word('0);
        send_word(csa_pkg::OBJ_W'(1));
        send_word(csa_pkg::OBJ_W'(64));
        send_word(csa_pkg::OBJ_W'(65));
        send_word(csa_pkg::OBJ_W'(csa_pkg::OBJ_MAX));

        // Only one count at zero still turns padding off.
        settle();
        set_counts(5'd0, 5'd9);
        send_word('0);
        send_word(csa_pkg::OBJ_W'(63));
        send_word(csa_pkg::OBJ_W'(64));
        send_word(csa_pkg::OBJ_W'(csa_pkg::OBJ_MAX));

        // Both counts at the top of their range; a zero size steps up to one line.
        settle();
        set_counts(5'd31, 5'd31);
        send_word('0);
        send_word(csa_pkg::OBJ_W'(1));
        send_word(csa_pkg::OBJ_W'(31 * 64));
        send_word(csa_pkg::OBJ_W'(31 * 64 + 1));
        send_word(csa_pkg::OBJ_W'(csa_pkg::OBJ_MAX));
        send_word(csa_pkg::OBJ_W'('hAAAAAA));
        send_word(csa_pkg::OBJ_W'('h555555));

        // A product of 210 forces the longest searches, up to ten counts.
        settle();
        set_counts(5'd15, 5'd14);
        send_word('0);
        send_word(csa_pkg::OBJ_W'(209 * 64));
        send_word(csa_pkg::OBJ_W'(210 * 64));
        send_word(csa_pkg::OBJ_W'(2 * 64 + 1));

        // Random phases. The first third idles the receiver hard, the second the
        // sender, and the last lets both run flat out.
        for (int unsigned ph = 0; ph < PHASES; ph++) begin
            settle();
            if (ph < 8) begin
                set_counts(rank_pick[ph], chan_pick[ph]);
            end else begin
                set_counts(csa_pkg::CFG_W'($urandom_range(0, 31)),
                           csa_pkg::CFG_W'($urandom_range(0, 31)));
            end
            if (ph < 4) begin
                tx_idle_pct = 24;
                rx_idle_pct <= 82;
            end else if (ph < 8) begin
                tx_idle_pct = 82;
                rx_idle_pct <= 24;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct <= 0;
            end
            for (int unsigned n = 0; n < PHASE_WORDS; n++) begin
                // One long receiver hold while the sender keeps offering, so that
                // the unit fills and stalls its input.
                if (ph == 1 && n == 20) begin
                    rx_hold_req <= 1'b1;
                end
                // One pause in which the sender waits for every stride word.
                if (ph == 5 && n == 50) begin
                    settle();
                end
                case ($urandom_range(0, 9))
                    0, 1, 2: size = csa_pkg::OBJ_W'($urandom_range(0, 4095));
                    3, 4: begin
                        // Sizes just around a line boundary.
                        k    = $urandom_range(0, (csa_pkg::OBJ_MAX + 1) / LINE_BYTES - 1);
                        size = csa_pkg::OBJ_W'(k * LINE_BYTES + $urandom_range(0, 2) - 1);
                    end
                    5: size = csa_pkg::OBJ_W'(csa_pkg::OBJ_MAX - $urandom_range(0, 130));
                    default: size = csa_pkg::OBJ_W'($urandom());
                endcase
                send_word(size);
            end
        end

        settle();
        // Leave time for any stray stride word to show up.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (ledger.clean()) begin
            $display("coprime_stride_size_align_unit: match");
        end else begin
            $display("coprime_stride_size_align_unit: mismatch");
        end
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/csa_pkg.sv
hw/rtl/csa_useq.sv
hw/rtl/coprime_stride_size_align_unit.sv
verif/tb_coprime_stride_size_align_unit.sv
